[hw/rtl/rrss_pkg.sv]
// Shared types and constants for the round-robin scheduler with sleep timer.
package rrss_pkg;

  localparam int CMD_W    = 2;
  localparam int TID_W    = 3;
  localparam int TST_W    = 2;
  localparam int CYC_W    = 32;
  localparam int MS_W     = 16;
  localparam int MASK_W   = 8;
  localparam int TIME_W   = 32;

  localparam logic [TIME_W-1:0] TIME_NONE = '1;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK      = 2'd0,
    CMD_YIELD     = 2'd1,
    CMD_SLEEP     = 2'd2,
    CMD_SET_STATE = 2'd3
  } cmd_t;

  typedef enum logic [TST_W-1:0] {
    TS_FREE     = 2'd0,
    TS_RUNNABLE = 2'd1,
    TS_BLOCKED  = 2'd2,
    TS_SLEEPING = 2'd3
  } tstate_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TICK_CHK,
    S_WAKE,
    S_WAKE_FIN,
    S_DIV,
    S_SLP_UPD,
    S_PICK,
    S_DONE
  } fsm_t;

  // controller -> datapath
  typedef struct packed {
    logic clr_result;
    logic tick_inc;
    logic scan_start;
    logic pick_start;
    logic scan_step;
    logic wake_step;
    logic wake_fin;
    logic set_write;
    logic div_start;
    logic div_step;
    logic sleep_upd;
    logic pick_hit;
    logic pick_none;
    logic load_out;
  } ctrl_t;

  // datapath -> controller
  typedef struct packed {
    logic tick_due;
    logic cycles_zero;
    logic scan_last;
    logic rd_runnable;
    logic div_done;
    logic out_busy;
  } stat_t;

endpackage

[hw/rtl/rrss_req_if.sv]
// Request channel: one scheduler command item per handshake.
interface rrss_req_if import rrss_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] command;
  logic [TID_W-1:0] thread_index;
  logic [TST_W-1:0] new_state;
  logic [CYC_W-1:0] sleep_cycles;

  modport source (output valid, output command, output thread_index, output new_state,
                  output sleep_cycles, input ready);
  modport sink   (input valid, input command, input thread_index, input new_state,
                  input sleep_cycles, output ready);
endinterface

[hw/rtl/rrss_rsp_if.sv]
// Response channel: one result item per handshake.
interface rrss_rsp_if import rrss_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [TID_W-1:0]  current_thread;
  logic              no_runnable;
  logic [MS_W-1:0]   sleep_ms;
  logic [MASK_W-1:0] woken_mask;

  modport source (output valid, output current_thread, output no_runnable,
                  output sleep_ms, output woken_mask, input ready);
  modport sink   (input valid, input current_thread, input no_runnable,
                  input sleep_ms, input woken_mask, output ready);
endinterface

[hw/rtl/round_robin_scheduler_sleep_timer.sv]
// Top level of the round-robin thread scheduler with millisecond sleep timer.
//
// Channels: req carries one command item (tick, yield, sleep, set_state);
// rsp returns exactly one result item per command, in order. Both use
// valid/ready; an item moves on a rising edge with valid and ready high.
// Commands are handled one at a time: req.ready is high only while the
// controller is idle. The result sits in an output register, so a new
// command is taken while the previous result still waits on rsp.
// Work per command:
//   set_state: table write; zero-cycle sleep: no change
//   tick: clock increment, then at wake time a wake scan, one slot per cycle
//   yield: round-robin scan, one slot per cycle
//   sleep: reciprocal multiply by CYCLES_PER_MS, then the yield scan
// The scan makes one registered read of the thread tables per cycle; the
// divide latches its operand on accept and registers the product.
// Reset: thread 0 runnable, all others free, clock zero, no pending wake.
// A stalled rsp holds its item; a finished command waits for the output
// register to free before the controller returns to idle.
module round_robin_scheduler_sleep_timer import rrss_pkg::*; #(
  parameter int          THREADS       = 8,
  parameter int unsigned CYCLES_PER_MS = 80000
) (
  input logic        clk,
  input logic        rst,
  rrss_req_if.sink   req,
  rrss_rsp_if.source rsp
);

  ctrl_t ctrl;   // per-cycle commands from the sequencer
  stat_t stat;   // compare results and scan/divider progress

  // controller: owns req.ready and the command sequencing
  rrss_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req.valid),
    .req_command (req.command),
    .req_ready   (req.ready),
    .stat        (stat),
    .ctrl        (ctrl)
  );

  // datapath: tables, timers, divider and result register
  rrss_dp #(
    .THREADS       (THREADS),
    .CYCLES_PER_MS (CYCLES_PER_MS)
  ) u_dp (
    .clk                (clk),
    .rst                (rst),
    .ctrl               (ctrl),
    .stat               (stat),
    .req_thread_index   (req.thread_index),
    .req_new_state      (req.new_state),
    .req_sleep_cycles   (req.sleep_cycles),
    .rsp_valid          (rsp.valid),
    .rsp_ready          (rsp.ready),
    .rsp_current_thread (rsp.current_thread),
    .rsp_no_runnable    (rsp.no_runnable),
    .rsp_sleep_ms       (rsp.sleep_ms),
    .rsp_woken_mask     (rsp.woken_mask)
  );

endmodule

[hw/rtl/rrss_ctrl.sv]
// Scheduler controller: sequences tick, yield, sleep and set_state commands.
module rrss_ctrl import rrss_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  input  logic [CMD_W-1:0] req_command,
  output logic             req_ready,
  input  stat_t            stat,
  output ctrl_t            ctrl
);

  fsm_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctrl       = '0;
    req_ready  = 1'b0;
    case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          ctrl.clr_result = 1'b1;
          case (cmd_t'(req_command))
            CMD_TICK: begin
              ctrl.tick_inc = 1'b1;
              state_next    = S_TICK_CHK;
            end
            CMD_YIELD: begin
              ctrl.pick_start = 1'b1;
              state_next      = S_PICK;
            end
            CMD_SLEEP: begin
              if (stat.cycles_zero) begin
                state_next = S_DONE;
              end else begin
                ctrl.div_start = 1'b1;
                state_next     = S_DIV;
              end
            end
            CMD_SET_STATE: begin
              ctrl.set_write = 1'b1;
              state_next     = S_DONE;
            end
            default: begin
              state_next = S_DONE;
            end
          endcase
        end
      end
      S_TICK_CHK: begin
        if (stat.tick_due) begin
          ctrl.scan_start = 1'b1;
          state_next      = S_WAKE;
        end else begin
          state_next = S_DONE;
        end
      end
      S_WAKE: begin
        ctrl.wake_step = 1'b1;
        if (stat.scan_last) begin
          state_next = S_WAKE_FIN;
        end else begin
          ctrl.scan_step = 1'b1;
        end
      end
      S_WAKE_FIN: begin
        ctrl.wake_fin = 1'b1;
        state_next    = S_DONE;
      end
      S_DIV: begin
        if (stat.div_done) begin
          state_next = S_SLP_UPD;
        end else begin
          ctrl.div_step = 1'b1;
        end
      end
      S_SLP_UPD: begin
        ctrl.sleep_upd  = 1'b1;
        ctrl.pick_start = 1'b1;
        state_next      = S_PICK;
      end
      S_PICK: begin
        if (stat.rd_runnable) begin
          ctrl.pick_hit = 1'b1;
          state_next    = S_DONE;
        end else if (stat.scan_last) begin
          ctrl.pick_none = 1'b1;
          state_next     = S_DONE;
        end else begin
          ctrl.scan_step = 1'b1;
        end
      end
      S_DONE: begin
        if (!stat.out_busy) begin
          ctrl.load_out = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

[hw/rtl/rrss_dp.sv]
// Scheduler datapath: thread tables, ms clock, slot scan, divider, result register.
module rrss_dp import rrss_pkg::*; #(
  parameter int          THREADS       = 8,
  parameter int unsigned CYCLES_PER_MS = 80000
) (
  input  logic              clk,
  input  logic              rst,
  input  ctrl_t             ctrl,
  output stat_t             stat,
  input  logic [TID_W-1:0]  req_thread_index,
  input  logic [TST_W-1:0]  req_new_state,
  input  logic [CYC_W-1:0]  req_sleep_cycles,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output logic [TID_W-1:0]  rsp_current_thread,
  output logic              rsp_no_runnable,
  output logic [MS_W-1:0]   rsp_sleep_ms,
  output logic [MASK_W-1:0] rsp_woken_mask
);

  localparam int AW = $clog2(THREADS);
  localparam int unsigned DIVISOR = (CYCLES_PER_MS == 0) ? 1 : CYCLES_PER_MS;
  // q = (x * MUL_K) >> DIV_SH is exact for every 32-bit x
  localparam int DIV_SH = CYC_W + $clog2(DIVISOR);
  localparam int PROD_W = 2*CYC_W + 1;
  localparam logic [PROD_W:0] DIV_POW = (PROD_W+1)'(1) << DIV_SH;
  localparam logic [CYC_W:0] MUL_K = (CYC_W+1)'((DIV_POW + DIVISOR - 1) / DIVISOR);
  localparam logic [AW-1:0] LAST_IDX = AW'(THREADS - 1);

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] v);
    return (v == LAST_IDX) ? '0 : v + 1'b1;
  endfunction

  // architectural state
  logic [TIME_W-1:0] sys_ms;
  logic [TIME_W-1:0] next_wake;
  logic [AW-1:0]     running;

  // thread tables
  logic [TST_W-1:0]  ts_mem [THREADS];
  logic [THREADS-1:0] ts_vld;
  logic [TIME_W-1:0] wt_mem [THREADS];

  // scan
  logic [AW-1:0]     idx, idx_next, cnt;
  logic [TST_W-1:0]  rd_state;
  logic [TIME_W-1:0] rd_wake;
  logic [TIME_W-1:0] min_rel;
  logic [TIME_W-1:0] rel;
  logic              sleeping, wake_hit;

  // table write port
  logic              ts_we;
  logic [AW-1:0]     ts_wa;
  logic [TST_W-1:0]  ts_wd;
  logic              set_ok;

  // divider
  logic [CYC_W-1:0]  div_in;
  logic [PROD_W-1:0] prod;
  logic              div_full;
  logic [CYC_W-1:0]  quo;
  logic [TIME_W-1:0] wake_new;

  // per-item results
  logic              none;
  logic [MS_W-1:0]   ms;
  logic [MASK_W-1:0] woken;

  always_comb begin
    idx_next = idx;
    if (ctrl.scan_start) begin
      idx_next = '0;
    end else if (ctrl.pick_start) begin
      idx_next = wrap_inc(running);
    end else if (ctrl.scan_step) begin
      idx_next = wrap_inc(idx);
    end
  end

  assign sleeping = (rd_state == TS_SLEEPING);
  assign wake_hit = sleeping && (rd_wake == sys_ms);
  assign rel      = rd_wake - sys_ms;
  assign set_ok   = (32'(req_thread_index) < THREADS) && (req_new_state <= TS_BLOCKED);
  assign wake_new = quo + sys_ms;

  always_comb begin
    ts_we = 1'b0;
    ts_wa = idx;
    ts_wd = TS_RUNNABLE;
    if (ctrl.set_write && set_ok) begin
      ts_we = 1'b1;
      ts_wa = AW'(req_thread_index);
      ts_wd = req_new_state;
    end else if (ctrl.sleep_upd) begin
      ts_we = 1'b1;
      ts_wa = running;
      ts_wd = TS_SLEEPING;
    end else if (ctrl.wake_step && wake_hit) begin
      ts_we = 1'b1;
      ts_wa = idx;
      ts_wd = TS_RUNNABLE;
    end
  end

  // tables: registered read at the index the scan moves to
  always_ff @(posedge clk) begin
    rd_wake <= wt_mem[idx_next];
    if (ts_vld[idx_next]) begin
      rd_state <= ts_mem[idx_next];
    end else begin
      rd_state <= (idx_next == '0) ? TS_RUNNABLE : TS_FREE;
    end
    if (ts_we) begin
      ts_mem[ts_wa] <= ts_wd;
    end
    if (ctrl.sleep_upd) begin
      wt_mem[running] <= wake_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ts_vld <= '0;
    end else if (ts_we) begin
      ts_vld[ts_wa] <= 1'b1;
    end
  end

  // scan index and step count
  always_ff @(posedge clk) begin
    idx <= idx_next;
    if (ctrl.scan_start || ctrl.pick_start) begin
      cnt <= '0;
    end else if (ctrl.scan_step) begin
      cnt <= cnt + 1'b1;
    end
  end

  // clock, earliest wake, running thread
  always_ff @(posedge clk) begin
    if (rst) begin
      sys_ms    <= '0;
      next_wake <= TIME_NONE;
      running   <= '0;
    end else begin
      if (ctrl.tick_inc) begin
        sys_ms <= sys_ms + 1'b1;
      end
      if (ctrl.wake_fin) begin
        next_wake <= min_rel + sys_ms;
      end else if (ctrl.sleep_upd && (quo < (next_wake - sys_ms))) begin
        next_wake <= wake_new;
      end
      if (ctrl.pick_hit) begin
        running <= idx;
      end
    end
  end

  // wake scan and per-item result fields
  always_ff @(posedge clk) begin
    if (ctrl.scan_start) begin
      min_rel <= TIME_NONE;
    end else if (ctrl.wake_step && sleeping && !wake_hit && (rel < min_rel)) begin
      min_rel <= rel;
    end
    if (ctrl.clr_result) begin
      none  <= 1'b0;
      ms    <= '0;
      woken <= '0;
    end else begin
      if (ctrl.wake_step && wake_hit) begin
        woken <= woken | (MASK_W'(1) << idx);
      end
      if (ctrl.sleep_upd) begin
        ms <= quo[MS_W-1:0];
      end
      if (ctrl.pick_none) begin
        none <= 1'b1;
      end
    end
  end

  // divide by CYCLES_PER_MS: operand latched on accept, product registered in the cycle after
  always_ff @(posedge clk) begin
    if (ctrl.div_start) begin
      div_in   <= req_sleep_cycles;
      div_full <= 1'b0;
    end else if (ctrl.div_step) begin
      prod     <= PROD_W'(div_in) * PROD_W'(MUL_K);
      div_full <= 1'b1;
    end
  end

  assign quo = CYC_W'(prod >> DIV_SH);

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (ctrl.load_out) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_out) begin
      rsp_current_thread <= TID_W'(running);
      rsp_no_runnable    <= none;
      rsp_sleep_ms       <= ms;
      rsp_woken_mask     <= woken;
    end
  end

  assign stat.tick_due    = (sys_ms == next_wake);
  assign stat.cycles_zero = (req_sleep_cycles == '0);
  assign stat.scan_last   = (cnt == LAST_IDX);
  assign stat.rd_runnable = (rd_state == TS_RUNNABLE);
  assign stat.div_done    = div_full;
  assign stat.out_busy    = rsp_valid && !rsp_ready;

endmodule

[hw/rtl/rrss_checker.sv]
// Port-level checks for the scheduler, bound to the top level.
module rrss_checker import rrss_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              req_valid,
  input logic              req_ready,
  input logic              rsp_valid,
  input logic              rsp_ready,
  input logic [TID_W-1:0]  rsp_current_thread,
  input logic              rsp_no_runnable,
  input logic [MS_W-1:0]   rsp_sleep_ms,
  input logic [MASK_W-1:0] rsp_woken_mask
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("rsp valid dropped while stalled");

  a_rsp_stable: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> $stable(rsp_current_thread) && $stable(rsp_no_runnable)
      && $stable(rsp_sleep_ms) && $stable(rsp_woken_mask))
    else $error("rsp payload changed while stalled");

  a_tick_fields: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_woken_mask != '0) |-> !rsp_no_runnable && (rsp_sleep_ms == '0))
    else $error("wake result carries reschedule fields");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("second item taken while a command is in progress");

  a_ready_after_reset: assert property (@(posedge clk)
    rst |=> req_ready)
    else $error("not idle after reset");

endmodule

bind round_robin_scheduler_sleep_timer rrss_checker u_rrss_checker (
  .clk                (clk),
  .rst                (rst),
  .req_valid          (req.valid),
  .req_ready          (req.ready),
  .rsp_valid          (rsp.valid),
  .rsp_ready          (rsp.ready),
  .rsp_current_thread (rsp.current_thread),
  .rsp_no_runnable    (rsp.no_runnable),
  .rsp_sleep_ms       (rsp.sleep_ms),
  .rsp_woken_mask     (rsp.woken_mask)
);

[bench/round_robin_scheduler_sleep_timer_test.sv]
// Self-checking testbench for the round-robin scheduler with millisecond sleep timer.
`timescale 1ns / 1ps

module round_robin_scheduler_sleep_timer_test;
  import rrss_pkg::*;

  localparam int          THREADS       = 8;
  localparam int unsigned CYCLES_PER_MS = 80000;
  // Slowest command is a sleep (divide, then scan); 885 items with
  // sender gaps, receiver stalls and two long hold-offs stay far below this.
  localparam int          CYCLE_LIMIT   = 400000;
  localparam int          RANDOM_ITEMS  = 850;
  localparam int          DRAIN_CYCLES  = 80;
  localparam int          HOLD_CYCLES   = 300;
  localparam int          PRINT_CAP     = 60;

  // One result item as the block should return it.
  typedef struct {
    logic [TID_W-1:0]  thread;
    logic              none;
    logic [MS_W-1:0]   ms;
    logic [MASK_W-1:0] mask;
  } sched_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  rrss_req_if req ();
  rrss_rsp_if rsp ();

  round_robin_scheduler_sleep_timer #(
    .THREADS       (THREADS),
    .CYCLES_PER_MS (CYCLES_PER_MS)
  ) u_dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  always #5 clk = ~clk;

  // Scheduler state as the predictor sees it.
  tstate_t            thr_state [THREADS];
  logic [TIME_W-1:0]  wake_at   [THREADS];
  logic [TIME_W-1:0]  clock_ms;
  logic [TIME_W-1:0]  next_wake;
  logic [TID_W-1:0]   cur_thread;

  sched_result_t expected_results [$];
  int            err_count;
  int            result_count;
  int            cycle_count;

  // Receiver stall control: the test asks for a hold-off, the receiver counts it.
  int hold_request;
  int hold_left;
  int rx_phase;
  int rx_mode;
  int rx_period;

  // ------------------------------------------------------------------
  // Predictor
  // ------------------------------------------------------------------

  task automatic reset_predictor();
    for (int i = 0; i < THREADS; i++) begin
      thr_state[i] = TS_FREE;
      wake_at[i]   = '0;
    end
    thr_state[0] = TS_RUNNABLE;
    clock_ms     = '0;
    next_wake    = TIME_NONE;
    cur_thread   = '0;
  endtask

  // Round-robin scan starting after the running thread; the running thread is
  // checked last. Leaves cur_thread alone when nothing is runnable.
  function automatic bit pick_runnable();
    logic [TID_W-1:0] slot;
    slot = cur_thread;
    for (int n = 0; n < THREADS; n++) begin
      slot = slot + 1'b1;
      if (thr_state[slot] == TS_RUNNABLE) begin
        cur_thread = slot;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  task automatic predict_command(input cmd_t cmd, input logic [TID_W-1:0] idx,
                                 input logic [TST_W-1:0] st, input logic [CYC_W-1:0] cyc,
                                 output sched_result_t want);
    logic [TIME_W-1:0] nearest;
    logic [TIME_W-1:0] rel;
    logic [TIME_W-1:0] ms;
    logic [TIME_W-1:0] wt;
    want = '{thread: '0, none: 1'b0, ms: '0, mask: '0};
    case (cmd)
      CMD_TICK: begin
        clock_ms = clock_ms + 1'b1;
        if (clock_ms == next_wake) begin
          // Wake everyone due now, then rebuild the earliest pending wake
          // relative to the clock so that wraparound orders correctly.
          nearest = TIME_NONE;
          for (int i = 0; i < THREADS; i++) begin
            if (thr_state[i] == TS_SLEEPING) begin
              if (wake_at[i] == clock_ms) begin
                thr_state[i] = TS_RUNNABLE;
                want.mask[i] = 1'b1;
              end else begin
                rel = wake_at[i] - clock_ms;
                if (rel < nearest) nearest = rel;
              end
            end
          end
          next_wake = nearest + clock_ms;
        end
      end
      CMD_YIELD: begin
        want.none = !pick_runnable();
      end
      CMD_SLEEP: begin
        // Zero cycles: no state change and no reschedule.
        if (cyc != '0) begin
          ms = cyc / CYCLES_PER_MS;
          wt = ms + clock_ms;
          wake_at[cur_thread] = wt;
          if ((wt - clock_ms) < (next_wake - clock_ms)) next_wake = wt;
          thr_state[cur_thread] = TS_SLEEPING;
          want.ms   = ms[MS_W-1:0];
          want.none = !pick_runnable();
        end
      end
      default: begin
        // Sleeping is not a state that set_state may write.
        if (st != TS_SLEEPING) thr_state[idx] = tstate_t'(st);
      end
    endcase
    want.thread = cur_thread;
  endtask

  // ------------------------------------------------------------------
  // Checking
  // ------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    err_count++;
    if (err_count <= PRINT_CAP) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  task automatic check_field(input string name, input int unsigned got,
                             input int unsigned want);
    if (got != want)
      report_mismatch($sformatf("result %0d %s: got %0d, expected %0d",
                                result_count, name, got, want));
  endtask

  // Every result item accepted by the receiver is matched to the oldest
  // prediction. Outputs are sampled on the rising edge; ready only moves on
  // the falling edge, so the sample is race free.
  always @(posedge clk) begin
    sched_result_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing outstanding",
                                  result_count));
      end else begin
        want = expected_results.pop_front();
        check_field("current_thread", 32'(rsp.current_thread), 32'(want.thread));
        check_field("no_runnable",    32'(rsp.no_runnable),    32'(want.none));
        check_field("sleep_ms",       32'(rsp.sleep_ms),       32'(want.ms));
        check_field("woken_mask",     32'(rsp.woken_mask),     32'(want.mask));
      end
      result_count++;
    end
  end

  // Receiver: a stall pattern (always ready, periodic stall, random stall) that
  // rx_phase redraws at random, overridden by a counted long hold-off.
  always @(negedge clk) begin
    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp.ready <= 1'b0;
    end else begin
      rx_phase++;
      if (rx_phase % 64 == 0) begin
        rx_mode   = $urandom_range(0, 2);
        rx_period = $urandom_range(2, 7);
      end
      case (rx_mode)
        0: begin
          rsp.ready <= 1'b1;
        end
        1: begin
          rsp.ready <= (rx_phase % rx_period) != 0;
        end
        default: begin
          rsp.ready <= ($urandom_range(0, 3) != 0);
        end
      endcase
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("round_robin_scheduler_sleep_timer: mismatch");
      $finish;
    end
  end

  // ------------------------------------------------------------------
  // Sender
  // ------------------------------------------------------------------

  // Called at a falling edge; returns at the falling edge after the item is
  // taken, with valid still high so a following item goes out back to back.
  task automatic send_command(input cmd_t cmd, input logic [TID_W-1:0] idx,
                              input logic [TST_W-1:0] st, input logic [CYC_W-1:0] cyc);
    sched_result_t want;
    req.valid        <= 1'b1;
    req.command      <= cmd;
    req.thread_index <= idx;
    req.new_state    <= st;
    req.sleep_cycles <= cyc;
    do @(posedge clk); while (!req.ready);
    predict_command(cmd, idx, st, cyc, want);
    expected_results.push_back(want);
    @(negedge clk);
  endtask

  task automatic sender_gap(input int n);
    if (n > 0) begin
      req.valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  // Mostly 1 to 6 ms plus a fraction so that sleepers actually come
  // due under the ticks; some zero, sub-millisecond and full-range requests.
  function automatic logic [CYC_W-1:0] rand_sleep_cycles();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 8)  return '0;
    if (pick < 14) return $urandom_range(1, CYCLES_PER_MS - 1);
    if (pick < 24) return $urandom;
    if (pick < 26) return '1;
    return $urandom_range(1, 6) * CYCLES_PER_MS + $urandom_range(0, CYCLES_PER_MS - 1);
  endfunction

  task automatic send_random_item();
    int unsigned pick;
    logic [TST_W-1:0] st;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      send_command(CMD_TICK, TID_W'($urandom), TST_W'($urandom), $urandom);
    end else if (pick < 63) begin
      send_command(CMD_YIELD, TID_W'($urandom), TST_W'($urandom), $urandom);
    end else if (pick < 78) begin
      send_command(CMD_SLEEP, TID_W'($urandom), TST_W'($urandom), rand_sleep_cycles());
    end else begin
      // Lean toward runnable so the round robin has something to pick.
      st = ($urandom_range(0, 1) != 0) ? TS_RUNNABLE : TST_W'($urandom);
      send_command(CMD_SET_STATE, TID_W'($urandom), st, $urandom);
    end
  endtask

  // ------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------

  // Out of reset only thread 0 runs; a yield comes back to it, and with it
  // blocked the scan finds nothing.
  task automatic test_reset_and_yield();
    send_command(CMD_TICK, '0, '0, '0);
    send_command(CMD_YIELD, '0, '0, '0);
    send_command(CMD_SET_STATE, 3'd0, TS_BLOCKED, '0);
    send_command(CMD_YIELD, '0, '0, '0);
  endtask

  // State writes, the ignored state code, and yield order wrapping 7 -> 0.
  task automatic test_set_state();
    send_command(CMD_SET_STATE, 3'd3, TS_SLEEPING, '1);
    send_command(CMD_SET_STATE, 3'd0, TS_RUNNABLE, '0);
    send_command(CMD_SET_STATE, 3'd5, TS_RUNNABLE, '0);
    send_command(CMD_SET_STATE, 3'd7, TS_RUNNABLE, '0);
    send_command(CMD_YIELD, 3'd7, 2'd3, '0);
    send_command(CMD_YIELD, '0, '0, '0);
    send_command(CMD_YIELD, '0, '0, '0);
  endtask

  // Zero sleep, two sleepers due at the same millisecond, the longest sleep
  // with nobody left to run, a sub-millisecond sleep that pins the wake time
  // to the current clock, and reviving that sleeper by a state write.
  task automatic test_sleep_and_wake();
    send_command(CMD_SLEEP, '0, '0, '0);
    send_command(CMD_SLEEP, '0, '0, 3 * CYCLES_PER_MS + 5);
    send_command(CMD_SLEEP, '0, '0, 3 * CYCLES_PER_MS);
    send_command(CMD_SLEEP, '0, '0, '1);
    repeat (3) send_command(CMD_TICK, '0, '0, '0);
    send_command(CMD_YIELD, '0, '0, '0);
    send_command(CMD_SLEEP, '0, '0, CYCLES_PER_MS - 1);
    send_command(CMD_TICK, '0, '0, '0);
    send_command(CMD_SET_STATE, 3'd0, TS_RUNNABLE, '0);
    send_command(CMD_SET_STATE, 3'd7, TS_FREE, '0);
    sender_gap(1);
  endtask

  // Receiver holds off for a long stretch while items keep coming, so the
  // output register fills and the block stops taking commands.
  task automatic test_backpressure();
    hold_request = HOLD_CYCLES;
    repeat (12) send_random_item();
    sender_gap(1);
  endtask

  // Bursts of random length, gaps of random length, some back to back.
  task automatic test_random_traffic();
    int sent;
    int burst;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 20);
      for (int i = 0; i < burst && sent < RANDOM_ITEMS; i++) begin
        send_random_item();
        sent++;
        if (sent == RANDOM_ITEMS / 2) hold_request = HOLD_CYCLES;
      end
      if ($urandom_range(0, 9) < 3) sender_gap(0);
      else sender_gap($urandom_range(1, 8));
    end
    sender_gap(1);
  endtask

  // Wait for every prediction to be met, then let the block sit long enough
  // that a spurious extra item would still show up.
  task automatic wait_drained();
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    req.valid        = 1'b0;
    req.command      = CMD_TICK;
    req.thread_index = '0;
    req.new_state    = '0;
    req.sleep_cycles = '0;
    rsp.ready        = 1'b0;
    err_count        = 0;
    result_count     = 0;
    cycle_count      = 0;
    hold_request     = 0;
    hold_left        = 0;
    rx_phase         = 0;
    rx_mode          = 0;
    rx_period        = 3;
    reset_predictor();

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_reset_and_yield();
    test_set_state();
    test_sleep_and_wake();
    test_backpressure();
    test_random_traffic();
    wait_drained();

    if (err_count == 0) begin
      $display("round_robin_scheduler_sleep_timer: match");
    end else begin
      $display("round_robin_scheduler_sleep_timer: mismatch");
    end
    $finish;
  end

endmodule
